FILE: design/ook_remote_frame_encoder_macros.svh
// Assertion macros for the OOK frame encoder.
// Both expect clk and rst_n in scope at the point of use.
`ifndef OOK_REMOTE_FRAME_ENCODER_MACROS_SVH
`define OOK_REMOTE_FRAME_ENCODER_MACROS_SVH

`ifndef SYNTHESIS
`define OOK_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define OOK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OOK_ASSERT(lbl, expr, msg)
`define OOK_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: design/ook_pkg.sv
`default_nettype none

package ook_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_TICKS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_REPEATS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_REPEATS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_REPEATS   = 3'd6;

  localparam logic [10:0] UNIT_TICKS_RST     = 11'd300;
  localparam logic [11:0] SHORT_TICKS_RST    = 12'd347;
  localparam logic [11:0] LONG_TICKS_RST     = 12'd930;
  localparam logic [13:0] GAP_TICKS_RST      = 14'd9943;
  localparam logic [6:0]  NORMAL_REPEATS_RST = 7'd3;
  localparam logic [6:0]  LONG_REPEATS_RST   = 7'd100;
  localparam logic [6:0]  CODE_REPEATS_RST   = 7'd4;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_UNIT = 2'd1;
  localparam logic [1:0] ACT_CODE = 2'd2;

  localparam logic [1:0] CMD_ON    = 2'd0;
  localparam logic [1:0] CMD_OTHER = 2'd2;

  localparam logic [4:0] LAST_BIT = 5'd23;

  typedef enum logic [1:0] {
    KIND_IDLE = 2'd0,
    KIND_UNIT = 2'd1,
    KIND_CODE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_SYNC_HI = 2'd0,
    PH_SYNC_LO = 2'd1,
    PH_BIT_HI  = 2'd2,
    PH_BIT_LO  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [10:0] unit_ticks;
    logic [11:0] short_ticks;
    logic [11:0] long_ticks;
    logic [13:0] gap_ticks;
    logic [6:0]  normal_repeats;
    logic [6:0]  long_repeats;
    logic [6:0]  code_repeats;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [19:0] device_id;
    logic [2:0]  button;
    logic [1:0]  command;
    logic [23:0] code_word;
  } item_t;

  typedef struct packed {
    logic line;
    logic busy_res;
    logic accepted;
    logic finished;
  } res_t;

  function automatic logic [15:0] seg_len(kind_t kind, logic [23:0] bits,
                                          logic [4:0] pos, phase_t phase, cfg_t cfg);
    logic        b;
    logic [15:0] u;
    logic [15:0] u3;
    logic [15:0] u31;
    logic [15:0] n;
    b   = (pos <= LAST_BIT) ? bits[LAST_BIT - pos] : bits[0];
    u   = {5'd0, cfg.unit_ticks};
    u3  = (u << 1) + u;
    u31 = (u << 5) - u;
    if (kind == KIND_UNIT) begin
      case (phase)
        PH_SYNC_HI: n = u;
        PH_SYNC_LO: n = u31;
        PH_BIT_HI:  n = b ? u : u3;
        default:    n = b ? u3 : u;
      endcase
    end else begin
      case (phase)
        PH_SYNC_HI: n = {4'd0, cfg.short_ticks};
        PH_SYNC_LO: n = {2'd0, cfg.gap_ticks};
        PH_BIT_HI:  n = b ? {4'd0, cfg.long_ticks} : {4'd0, cfg.short_ticks};
        default:    n = b ? {4'd0, cfg.short_ticks} : {4'd0, cfg.long_ticks};
      endcase
    end
    return (n == 16'd0) ? 16'd1 : n;
  endfunction

endpackage

`default_nettype wire

FILE: design/ook_cfg.sv
`default_nettype none

module ook_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [ook_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ook_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output ook_pkg::cfg_t                         cfg
);

  ook_pkg::cfg_t cfg_r;
  ook_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        ook_pkg::REG_UNIT_TICKS:     cfg_nxt.unit_ticks     = cfg_wdata[10:0];
        ook_pkg::REG_SHORT_TICKS:    cfg_nxt.short_ticks    = cfg_wdata[11:0];
        ook_pkg::REG_LONG_TICKS:     cfg_nxt.long_ticks     = cfg_wdata[11:0];
        ook_pkg::REG_GAP_TICKS:      cfg_nxt.gap_ticks      = cfg_wdata[13:0];
        ook_pkg::REG_NORMAL_REPEATS: cfg_nxt.normal_repeats = cfg_wdata[6:0];
        ook_pkg::REG_LONG_REPEATS:   cfg_nxt.long_repeats   = cfg_wdata[6:0];
        ook_pkg::REG_CODE_REPEATS:   cfg_nxt.code_repeats   = cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unit_ticks     <= ook_pkg::UNIT_TICKS_RST;
      cfg_r.short_ticks    <= ook_pkg::SHORT_TICKS_RST;
      cfg_r.long_ticks     <= ook_pkg::LONG_TICKS_RST;
      cfg_r.gap_ticks      <= ook_pkg::GAP_TICKS_RST;
      cfg_r.normal_repeats <= ook_pkg::NORMAL_REPEATS_RST;
      cfg_r.long_repeats   <= ook_pkg::LONG_REPEATS_RST;
      cfg_r.code_repeats   <= ook_pkg::CODE_REPEATS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: design/ook_core.sv
`default_nettype none

module ook_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step_en,
  input  wire ook_pkg::item_t  item,
  input  wire ook_pkg::cfg_t   cfg,
  output ook_pkg::res_t        res
);

  ook_pkg::kind_t  kind_r, kind_nxt;
  ook_pkg::phase_t phase_r, phase_nxt;
  logic [23:0]     bits_r, bits_nxt;
  logic [4:0]      pos_r, pos_nxt;
  logic [6:0]      reps_r, reps_nxt;
  logic [15:0]     ticks_r, ticks_nxt;
  logic            line_r, line_nxt;
  ook_pkg::res_t   res_r, res_nxt;

  logic            enter_en;
  ook_pkg::phase_t enter_phase;
  logic [15:0]     dec;
  logic [2:0]      ch;
  logic            cbit;
  logic [6:0]      reps_sel;

  always_comb begin
    kind_nxt    = kind_r;
    phase_nxt   = phase_r;
    bits_nxt    = bits_r;
    pos_nxt     = pos_r;
    reps_nxt    = reps_r;
    ticks_nxt   = ticks_r;
    line_nxt    = line_r;
    enter_en    = 1'b0;
    enter_phase = ook_pkg::PH_SYNC_HI;
    res_nxt     = '0;
    dec         = (ticks_r == 16'd0) ? 16'd0 : ticks_r - 16'd1;
    cbit        = (item.command != ook_pkg::CMD_ON);
    reps_sel    = (item.command == ook_pkg::CMD_OTHER) ? cfg.long_repeats
                                                       : cfg.normal_repeats;
    case (item.button)
      3'd1:    ch = 3'd0;
      3'd2:    ch = 3'd4;
      3'd3:    ch = 3'd2;
      3'd4:    ch = 3'd1;
      default: ch = 3'd7;
    endcase

    case (item.action)
      ook_pkg::ACT_UNIT, ook_pkg::ACT_CODE: begin
        if (kind_r == ook_pkg::KIND_IDLE) begin
          if (item.action == ook_pkg::ACT_UNIT) begin
            kind_nxt = ook_pkg::KIND_UNIT;
            bits_nxt = {item.device_id, cbit, ch};
            reps_nxt = (reps_sel == 7'd0) ? 7'd1 : reps_sel;
          end else begin
            kind_nxt = ook_pkg::KIND_CODE;
            bits_nxt = item.code_word;
            reps_nxt = (cfg.code_repeats == 7'd0) ? 7'd1 : cfg.code_repeats;
          end
          pos_nxt          = 5'd0;
          enter_en         = 1'b1;
          enter_phase      = ook_pkg::PH_SYNC_HI;
          res_nxt.accepted = 1'b1;
        end
      end
      ook_pkg::ACT_TICK: begin
        if (kind_r != ook_pkg::KIND_IDLE) begin
          ticks_nxt = dec;
          if (dec == 16'd0) begin
            case (phase_r)
              ook_pkg::PH_SYNC_HI: begin
                enter_en    = 1'b1;
                enter_phase = ook_pkg::PH_SYNC_LO;
              end
              ook_pkg::PH_SYNC_LO: begin
                pos_nxt     = 5'd0;
                enter_en    = 1'b1;
                enter_phase = ook_pkg::PH_BIT_HI;
              end
              ook_pkg::PH_BIT_HI: begin
                enter_en    = 1'b1;
                enter_phase = ook_pkg::PH_BIT_LO;
              end
              default: begin
                if (pos_r < ook_pkg::LAST_BIT) begin
                  pos_nxt     = pos_r + 5'd1;
                  enter_en    = 1'b1;
                  enter_phase = ook_pkg::PH_BIT_HI;
                end else begin
                  reps_nxt = reps_r - 7'd1;
                  pos_nxt  = 5'd0;
                  if (reps_r != 7'd1) begin
                    enter_en    = 1'b1;
                    enter_phase = ook_pkg::PH_SYNC_HI;
                  end else begin
                    kind_nxt         = ook_pkg::KIND_IDLE;
                    phase_nxt        = ook_pkg::PH_SYNC_HI;
                    ticks_nxt        = 16'd0;
                    line_nxt         = 1'b0;
                    res_nxt.finished = 1'b1;
                  end
                end
              end
            endcase
          end
        end
      end
      default: ;
    endcase

    if (enter_en) begin
      phase_nxt = enter_phase;
      line_nxt  = (enter_phase == ook_pkg::PH_SYNC_HI) || (enter_phase == ook_pkg::PH_BIT_HI);
      ticks_nxt = ook_pkg::seg_len(kind_nxt, bits_nxt, pos_nxt, enter_phase, cfg);
    end

    res_nxt.line     = line_nxt;
    res_nxt.busy_res = (kind_nxt != ook_pkg::KIND_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= ook_pkg::KIND_IDLE;
      phase_r <= ook_pkg::PH_SYNC_HI;
      bits_r  <= '0;
      pos_r   <= '0;
      reps_r  <= '0;
      ticks_r <= '0;
      line_r  <= 1'b0;
    end else if (step_en) begin
      kind_r  <= kind_nxt;
      phase_r <= phase_nxt;
      bits_r  <= bits_nxt;
      pos_r   <= pos_nxt;
      reps_r  <= reps_nxt;
      ticks_r <= ticks_nxt;
      line_r  <= line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

FILE: design/ook_remote_frame_encoder.sv
// Channel  Direction  Handshake        Payload
// in       input      in_valid/stall   action, device_id, button, command, code_word
// out      output     out_valid/stall  line, busy_res, accepted, finished
// cfg      input      cfg_we           cfg_index, cfg_wdata
//
// One item per cycle sustained while out_stall stays low; an accepted item passes the input register,
// then the frame state update into the result register.
// Synchronous active-low reset clears control and frame state; payload registers are not reset.
// A stalled result holds the result register; the input register still takes one
// more item, after which in_stall rises until the result is taken.
`default_nettype none
`include "ook_remote_frame_encoder_macros.svh"

module ook_remote_frame_encoder (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      in_action,
  input  wire logic [19:0]                     in_device_id,
  input  wire logic [2:0]                      in_button,
  input  wire logic [1:0]                      in_command,
  input  wire logic [23:0]                     in_code_word,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_line,
  output logic                                 out_busy_res,
  output logic                                 out_accepted,
  output logic                                 out_finished,
  input  wire logic                            cfg_we,
  input  wire logic [ook_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ook_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  ook_pkg::cfg_t  cfg;
  ook_pkg::item_t item_r;
  ook_pkg::res_t  res;
  logic           a_valid_r, a_valid_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           adv_b;
  logic           take_a;
  logic           in_take;

  assign adv_b    = !out_valid_r || !out_stall;
  assign take_a   = a_valid_r && adv_b;
  assign in_stall = a_valid_r && !adv_b;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_take) begin
      a_valid_nxt = 1'b1;
    end else if (take_a) begin
      a_valid_nxt = 1'b0;
    end
    out_valid_nxt = adv_b ? a_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.action    <= in_action;
      item_r.device_id <= in_device_id;
      item_r.button    <= in_button;
      item_r.command   <= in_command;
      item_r.code_word <= in_code_word;
    end
  end

  ook_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ook_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (take_a),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  assign out_valid    = out_valid_r;
  assign out_line     = res.line;
  assign out_busy_res = res.busy_res;
  assign out_accepted = res.accepted;
  assign out_finished = res.finished;

  `OOK_ASSERT(a_acc_busy, !(out_valid && out_accepted) || out_busy_res, "start not busy")
  `OOK_ASSERT(a_fin_idle, !(out_valid && out_finished) || !(out_busy_res || out_line), "not idle")
  `OOK_ASSERT(a_idle_low, !(out_valid && !out_busy_res) || !out_line, "line high while idle")
  `OOK_ASSERT_NEXT(a_stall_hold, in_stall, a_valid_r, "input register emptied while stalled")

endmodule

`default_nettype wire

FILE: tb/ook_remote_frame_encoder_tb.sv
`timescale 1ns / 1ps

module ook_remote_frame_encoder_tb;

  localparam logic [1:0] ACT_NONE    = 2'd3;
  localparam int         CYCLE_LIMIT = 10_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [1:0]                     in_action = '0;
  logic [19:0]                    in_device_id = '0;
  logic [2:0]                     in_button = '0;
  logic [1:0]                     in_command = '0;
  logic [23:0]                    in_code_word = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_line;
  logic                           out_busy_res;
  logic                           out_accepted;
  logic                           out_finished;
  logic                           cfg_we = 1'b0;
  logic [ook_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ook_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  ook_remote_frame_encoder u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_device_id (in_device_id),
    .in_button    (in_button),
    .in_command   (in_command),
    .in_code_word (in_code_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_line     (out_line),
    .out_busy_res (out_busy_res),
    .out_accepted (out_accepted),
    .out_finished (out_finished),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the encoder
  ook_pkg::cfg_t   shadow_cfg = '{ook_pkg::UNIT_TICKS_RST, ook_pkg::SHORT_TICKS_RST,
                                  ook_pkg::LONG_TICKS_RST, ook_pkg::GAP_TICKS_RST,
                                  ook_pkg::NORMAL_REPEATS_RST, ook_pkg::LONG_REPEATS_RST,
                                  ook_pkg::CODE_REPEATS_RST};
  ook_pkg::kind_t  tx_kind  = ook_pkg::KIND_IDLE;
  logic [23:0]     tx_bits  = '0;
  logic [4:0]      tx_pos   = '0;
  logic [6:0]      tx_reps  = '0;
  ook_pkg::phase_t tx_phase = ook_pkg::PH_SYNC_HI;
  logic [15:0]     tx_left  = '0;
  logic            tx_line  = 1'b0;

  ook_pkg::res_t   line_forecast[$];
  ook_pkg::res_t   head;
  int              errors = 0;
  int unsigned     cycle_count = 0;
  int unsigned     hold_cycles = 0;
  bit              send_steady = 1'b0;
  bit              take_steady = 1'b0;

  function automatic logic [6:0] repeats_of(input logic [6:0] v);
    return (v == 7'd0) ? 7'd1 : v;
  endfunction

  function automatic logic [15:0] segment_ticks();
    logic b;
    int   u;
    int   n;
    b = tx_bits[ook_pkg::LAST_BIT - tx_pos];
    u = shadow_cfg.unit_ticks;
    if (tx_kind == ook_pkg::KIND_UNIT) begin
      case (tx_phase)
        ook_pkg::PH_SYNC_HI: n = u;
        ook_pkg::PH_SYNC_LO: n = 31 * u;
        ook_pkg::PH_BIT_HI:  n = b ? u : 3 * u;
        default:             n = b ? 3 * u : u;
      endcase
    end else begin
      case (tx_phase)
        ook_pkg::PH_SYNC_HI: n = shadow_cfg.short_ticks;
        ook_pkg::PH_SYNC_LO: n = shadow_cfg.gap_ticks;
        ook_pkg::PH_BIT_HI:  n = b ? shadow_cfg.long_ticks : shadow_cfg.short_ticks;
        default:             n = b ? shadow_cfg.short_ticks : shadow_cfg.long_ticks;
      endcase
    end
    if (n == 0) n = 1;
    return 16'(n);
  endfunction

  function automatic void enter_phase(input ook_pkg::phase_t p);
    tx_phase = p;
    tx_line  = (p == ook_pkg::PH_SYNC_HI) || (p == ook_pkg::PH_BIT_HI);
    tx_left  = segment_ticks();
  endfunction

  function automatic ook_pkg::res_t advance_encoder(input ook_pkg::item_t it);
    ook_pkg::res_t r;
    logic [2:0]    chan;
    logic          cmd_bit;
    r = '0;
    if (it.action == ook_pkg::ACT_UNIT || it.action == ook_pkg::ACT_CODE) begin
      if (tx_kind == ook_pkg::KIND_IDLE) begin
        if (it.action == ook_pkg::ACT_UNIT) begin
          case (it.button)
            3'd1:    chan = 3'd0;
            3'd2:    chan = 3'd4;
            3'd3:    chan = 3'd2;
            3'd4:    chan = 3'd1;
            default: chan = 3'd7;
          endcase
          cmd_bit = (it.command != ook_pkg::CMD_ON);
          tx_kind = ook_pkg::KIND_UNIT;
          tx_bits = {it.device_id, cmd_bit, chan};
          tx_reps = repeats_of(it.command == ook_pkg::CMD_OTHER ? shadow_cfg.long_repeats
                                                                : shadow_cfg.normal_repeats);
        end else begin
          tx_kind = ook_pkg::KIND_CODE;
          tx_bits = it.code_word;
          tx_reps = repeats_of(shadow_cfg.code_repeats);
        end
        tx_pos = '0;
        enter_phase(ook_pkg::PH_SYNC_HI);
        r.accepted = 1'b1;
      end
    end else if (it.action == ook_pkg::ACT_TICK && tx_kind != ook_pkg::KIND_IDLE) begin
      if (tx_left != 16'd0) tx_left = tx_left - 16'd1;
      if (tx_left == 16'd0) begin
        case (tx_phase)
          ook_pkg::PH_SYNC_HI: enter_phase(ook_pkg::PH_SYNC_LO);
          ook_pkg::PH_SYNC_LO: begin
            tx_pos = '0;
            enter_phase(ook_pkg::PH_BIT_HI);
          end
          ook_pkg::PH_BIT_HI:  enter_phase(ook_pkg::PH_BIT_LO);
          default: begin
            if (tx_pos < ook_pkg::LAST_BIT) begin
              tx_pos = tx_pos + 5'd1;
              enter_phase(ook_pkg::PH_BIT_HI);
            end else begin
              tx_reps = tx_reps - 7'd1;
              tx_pos  = '0;
              if (tx_reps != 7'd0) begin
                enter_phase(ook_pkg::PH_SYNC_HI);
              end else begin
                tx_kind    = ook_pkg::KIND_IDLE;
                tx_phase   = ook_pkg::PH_SYNC_HI;
                tx_left    = '0;
                tx_line    = 1'b0;
                r.finished = 1'b1;
              end
            end
          end
        endcase
      end
    end
    r.line     = tx_line;
    r.busy_res = (tx_kind != ook_pkg::KIND_IDLE);
    return r;
  endfunction

  function automatic ook_pkg::item_t make_item(input logic [1:0] act);
    ook_pkg::item_t it;
    it.action    = act;
    it.device_id = 20'($urandom);
    it.button    = 3'($urandom);
    it.command   = 2'($urandom);
    it.code_word = 24'($urandom);
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    if (send_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic int unsigned small_len(input int unsigned hi);
    return ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, hi);
  endfunction

  task automatic push_item(input ook_pkg::item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= it.action;
    in_device_id <= it.device_id;
    in_button    <= it.button;
    in_command   <= it.command;
    in_code_word <= it.code_word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    line_forecast.push_back(advance_encoder(it));
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (line_forecast.size() != 0) @(posedge clk);
  endtask

  task automatic tick_for(input int n);
    repeat (n) push_item(make_item(ook_pkg::ACT_TICK));
  endtask

  task automatic run_out();
    while (tx_kind != ook_pkg::KIND_IDLE) push_item(make_item(ook_pkg::ACT_TICK));
  endtask

  task automatic write_reg(input logic [ook_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[ook_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    case (idx)
      ook_pkg::REG_UNIT_TICKS:     shadow_cfg.unit_ticks     = value[10:0];
      ook_pkg::REG_SHORT_TICKS:    shadow_cfg.short_ticks    = value[11:0];
      ook_pkg::REG_LONG_TICKS:     shadow_cfg.long_ticks     = value[11:0];
      ook_pkg::REG_GAP_TICKS:      shadow_cfg.gap_ticks      = value[13:0];
      ook_pkg::REG_NORMAL_REPEATS: shadow_cfg.normal_repeats = value[6:0];
      ook_pkg::REG_LONG_REPEATS:   shadow_cfg.long_repeats   = value[6:0];
      ook_pkg::REG_CODE_REPEATS:   shadow_cfg.code_repeats   = value[6:0];
      default: ;
    endcase
  endtask

  task automatic set_timing(input int unsigned u_len, s_len, l_len, g_len,
                            n_rep, l_rep, c_rep);
    wait_results();
    write_reg(ook_pkg::REG_UNIT_TICKS, u_len);
    write_reg(ook_pkg::REG_SHORT_TICKS, s_len);
    write_reg(ook_pkg::REG_LONG_TICKS, l_len);
    write_reg(ook_pkg::REG_GAP_TICKS, g_len);
    write_reg(ook_pkg::REG_NORMAL_REPEATS, n_rep);
    write_reg(ook_pkg::REG_LONG_REPEATS, l_rep);
    write_reg(ook_pkg::REG_CODE_REPEATS, c_rep);
    cfg_we <= 1'b0;
  endtask

  // sync high at the reset short length; long, gap and repeats shortened beforehand, short during sync high
  task automatic test_reset_values();
    send_steady = 1'b1;
    push_item(make_item(ook_pkg::ACT_TICK));
    wait_results();
    write_reg(ook_pkg::REG_LONG_TICKS, 1);
    write_reg(ook_pkg::REG_GAP_TICKS, 1);
    write_reg(ook_pkg::REG_CODE_REPEATS, 1);
    cfg_we <= 1'b0;
    push_item(make_item(ook_pkg::ACT_CODE));
    tick_for(346);
    wait_results();
    write_reg(ook_pkg::REG_SHORT_TICKS, 1);
    cfg_we <= 1'b0;
    run_out();
    send_steady = 1'b0;
  endtask

  task automatic test_idle_items();
    push_item(make_item(ook_pkg::ACT_TICK));
    push_item(make_item(ACT_NONE));
    push_item(make_item(ook_pkg::ACT_TICK));
  endtask

  // zero lengths act as one tick, zero repeats as one repeat
  task automatic test_zero_registers();
    ook_pkg::item_t it;
    set_timing(0, 0, 0, 0, 0, 0, 0);
    it = make_item(ook_pkg::ACT_UNIT);
    it.device_id = '1;
    it.button    = 3'd0;
    it.command   = ook_pkg::CMD_OTHER;
    push_item(it);
    run_out();
    it = make_item(ook_pkg::ACT_CODE);
    it.code_word = '1;
    push_item(it);
    run_out();
  endtask

  task automatic test_unit_channels();
    ook_pkg::item_t it;
    int             b;
    set_timing(1, 1, 1, 1, 1, 2, 1);
    for (b = 1; b < 5; b++) begin
      it = make_item(ook_pkg::ACT_UNIT);
      it.button    = 3'(b);
      it.command   = 2'(b - 1);
      it.device_id = b[0] ? 20'h00000 : 20'hFFFFF;
      push_item(it);
      if (b == 1) begin
        tick_for(3);
        push_item(make_item(ook_pkg::ACT_CODE));
        push_item(make_item(ook_pkg::ACT_UNIT));
        push_item(make_item(ACT_NONE));
      end
      run_out();
    end
  endtask

  task automatic test_code_frames();
    ook_pkg::item_t it;
    set_timing(1, 1, 2, 3, 1, 1, 1);
    it = make_item(ook_pkg::ACT_CODE);
    it.code_word = '0;
    push_item(it);
    run_out();
    it.code_word = '1;
    push_item(it);
    tick_for(2);
    push_item(make_item(ook_pkg::ACT_UNIT));
    run_out();
    push_item(make_item(ook_pkg::ACT_CODE));
    run_out();
  endtask

  // lengths written during a segment apply from the next segment
  task automatic test_mid_segment_writes();
    ook_pkg::item_t it;
    send_steady = 1'b1;
    set_timing(2, 9, 5, 12, 1, 1, 1);
    it = make_item(ook_pkg::ACT_CODE);
    it.code_word = it.code_word | 24'h800000;
    push_item(it);
    tick_for(4);
    set_timing(2, 1, 5, 1, 1, 1, 1);
    tick_for(6);
    set_timing(2, 1, 1, 1, 1, 1, 1);
    run_out();
    send_steady = 1'b0;
  endtask

  task automatic test_random();
    ook_pkg::item_t it;
    int             phase;
    int             counted;
    int             r;
    for (phase = 0; phase < 4; phase++) begin
      set_timing(small_len(2), small_len(3), small_len(3), small_len(6),
                 small_len(2), small_len(2), small_len(2));
      send_steady = (phase == 1);
      take_steady = (phase == 2);
      counted = 0;
      while (counted < 70) begin
        r = $urandom_range(0, 99);
        if (tx_kind == ook_pkg::KIND_IDLE) begin
          if (r < 85) begin
            it = make_item(r < 25 ? ook_pkg::ACT_UNIT : ook_pkg::ACT_CODE);
            counted++;
          end else begin
            it = make_item(r < 92 ? ACT_NONE : ook_pkg::ACT_TICK);
          end
        end else if (r < 3) begin
          it = make_item(r < 2 ? ook_pkg::ACT_UNIT : ook_pkg::ACT_CODE);
        end else if (r < 5) begin
          it = make_item(ACT_NONE);
        end else begin
          it = make_item(ook_pkg::ACT_TICK);
          counted++;
        end
        push_item(it);
        if (counted == 35 || $urandom_range(0, 199) == 0) wait_results();
      end
    end
    send_steady = 1'b0;
    take_steady = 1'b0;
  endtask

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s expected %0b got %0b", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (!take_steady && $urandom_range(0, 99) < 20) begin
      out_stall   <= 1'b1;
      hold_cycles <= ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40)
                                                  : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (line_forecast.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected item, expected none, got line %0b busy %0b acc %0b fin %0b",
                 $time, out_line, out_busy_res, out_accepted, out_finished);
      end else begin
        head = line_forecast.pop_front();
        check_field("line", head.line, out_line);
        check_field("busy_res", head.busy_res, out_busy_res);
        check_field("accepted", head.accepted, out_accepted);
        check_field("finished", head.finished, out_finished);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_idle_items();
    test_zero_registers();
    test_unit_channels();
    test_code_frames();
    test_mid_segment_writes();
    test_random();
    wait_results();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
